// File: hdl/radix_string_to_integer_defines.svh
// Assertion macros shared by the radix string-to-integer converter.
`ifndef RADIX_STRING_TO_INTEGER_DEFINES_SVH
`define RADIX_STRING_TO_INTEGER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RSTI_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsti: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RSTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsti: next-cycle check failed");
`else
`define RSTI_ASSERT_IMPLY(lbl, ante, cons)
`define RSTI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/rsti_pkg.sv
// Types and constants of the radix string-to-integer converter.
package rsti_pkg;

	localparam int MAX_RADIX = 16;
	localparam int IDX_W     = $clog2(MAX_RADIX);

	typedef logic [7:0]  byte_t;
	typedef logic [63:0] symbols_t;
	typedef logic [4:0]  radix_t;
	typedef logic [1:0]  cfg_index_t;

	// Configuration register indexes.
	localparam cfg_index_t CFG_SYMBOLS_LOW  = 2'd0;
	localparam cfg_index_t CFG_SYMBOLS_HIGH = 2'd1;
	localparam cfg_index_t CFG_RADIX        = 2'd2;

	// Reset alphabet: "01234567" and "89abcdef", radix 16.
	localparam symbols_t SYMBOLS_LOW_RST  = 64'd3978425819141910832;
	localparam symbols_t SYMBOLS_HIGH_RST = 64'd7378413942531504440;
	localparam radix_t   RADIX_RST        = 5'd16;

	// Characters with a meaning of their own.
	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_TAB   = 8'h09;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_PLUS  = 8'h2B;
	localparam byte_t CH_MINUS = 8'h2D;

	// Result of looking a character up in the alphabet.
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} digit_t;

endpackage

// File: hdl/rsti_if.sv
// Channel interfaces of the radix string-to-integer converter.
interface rsti_chars_if import rsti_pkg::*;;
	logic  valid;
	logic  ready;
	byte_t character;

	modport source (output valid, output character, input ready);
	modport sink (input valid, input character, output ready);
endinterface

interface rsti_result_if import rsti_pkg::*;;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               alphabet_invalid;

	modport source (output valid, output value, output alphabet_invalid, input ready);
	modport sink (input valid, input value, input alphabet_invalid, output ready);
endinterface

interface rsti_cfg_if import rsti_pkg::*;;
	logic       valid;
	logic       ready;
	cfg_index_t index;
	symbols_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/rsti_alphabet.sv
// Alphabet lookup and alphabet validation of the converter.
module rsti_alphabet import rsti_pkg::*; (
	input  symbols_t symbols_low,
	input  symbols_t symbols_high,
	input  radix_t   radix,
	input  byte_t    character,
	output digit_t   digit,
	output logic     bad
);

	byte_t                sym [MAX_RADIX];
	logic [MAX_RADIX-1:0] match;
	logic [MAX_RADIX-1:0] sym_bad;
	logic [MAX_RADIX-1:0] dup;
	radix_t               n_used;

	always_comb begin
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (i < 8) begin
				sym[i] = symbols_low[8*(i%8) +: 8];
			end else begin
				sym[i] = symbols_high[8*(i%8) +: 8];
			end
		end
	end

	assign n_used = (radix > radix_t'(MAX_RADIX)) ? radix_t'(MAX_RADIX) : radix;

	// Parallel compare, then the lowest matching position wins.
	always_comb begin
		digit = '0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			match[i] = (sym[i] == character) && (radix_t'(i) < n_used);
		end
		for (int i = MAX_RADIX - 1; i >= 0; i--) begin
			if (match[i]) begin
				digit.hit   = 1'b1;
				digit.index = IDX_W'(i);
			end
		end
	end

	// A symbol in use may not be a sign, a space or NUL, nor repeat later on.
	always_comb begin
		for (int i = 0; i < MAX_RADIX; i++) begin
			sym_bad[i] = (radix_t'(i) < radix) &&
				(sym[i] == CH_NUL || sym[i] == CH_PLUS ||
				 sym[i] == CH_MINUS || sym[i] == CH_SPACE);
			dup[i] = 1'b0;
			for (int j = i + 1; j < MAX_RADIX; j++) begin
				if ((radix_t'(j) < radix) && (sym[i] == sym[j])) begin
					dup[i] = 1'b1;
				end
			end
		end
		bad = (radix < 5'd2) || (radix > radix_t'(MAX_RADIX)) || (|sym_bad) || (|dup);
	end

endmodule

// File: hdl/radix_string_to_integer.sv
// Top level of the radix string-to-integer converter.
//
// The chars channel takes one text byte per word. Leading whitespace (bytes 9
// to 13 and space) is skipped, then each plus or minus is read and a minus
// toggles the sign, then bytes found in the configured alphabet are digits:
// the accumulator becomes acc * radix + index, wrapping at 32 bits. The first
// byte that is not a digit ends the digits, and later bytes are dropped.
// A NUL byte sends one word on the result channel with the signed value (or
// zero and alphabet_invalid set if the alphabet fails its check) and starts
// a fresh parse. All other bytes produce no result word.
// Throughput is one byte per cycle while no NUL is waiting: each byte goes
// through the input register and a single multiply-add by the radix into the
// parse registers. A NUL goes from the input register into the result
// register, which raises result valid. The result register holds a word while
// the receiver stalls; bytes that produce no word keep flowing, and a NUL
// waits in the input register until the word ahead is taken. The cfg channel
// is always ready; the alphabet check is registered, so after a write it takes
// effect after the lookup does. Reset restores the alphabet "0123456789abcdef",
// radix 16, and an empty parse.
`include "radix_string_to_integer_defines.svh"

module radix_string_to_integer import rsti_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	rsti_cfg_if.sink       cfg,
	rsti_chars_if.sink     chars,
	rsti_result_if.source  result
);

	// Parse phases.
	localparam logic [1:0] PH_SPACE  = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGIT  = 2'd2;
	localparam logic [1:0] PH_IGNORE = 2'd3;

	// Configuration registers and the registered alphabet check.
	symbols_t symbols_low_q;
	symbols_t symbols_high_q;
	radix_t   radix_q;
	logic     bad_q;

	// Input register.
	logic  valid_s1;
	byte_t char_s1;

	// Parse state.
	logic [1:0]  phase_q;
	logic        neg_q;
	logic [31:0] acc_q;

	// Result register.
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_invalid_q;

	digit_t      digit;
	logic        bad;
	logic        is_nul;
	logic        is_ws;
	logic        s1_adv;
	logic        s1_fire;
	logic [1:0]  ph_eff;
	logic [1:0]  phase_d;
	logic        neg_d;
	logic [31:0] acc_d;
	logic [31:0] mac;
	logic [31:0] signed_acc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbols_low_q  <= SYMBOLS_LOW_RST;
			symbols_high_q <= SYMBOLS_HIGH_RST;
			radix_q        <= RADIX_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg.data;
				CFG_SYMBOLS_HIGH: symbols_high_q <= cfg.data;
				CFG_RADIX:        radix_q        <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	rsti_alphabet u_alphabet (
		.symbols_low  (symbols_low_q),
		.symbols_high (symbols_high_q),
		.radix        (radix_q),
		.character    (char_s1),
		.digit        (digit),
		.bad          (bad)
	);

	// The pairwise symbol check depends only on configuration, so it is
	// registered to keep it off the per-byte path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else begin
			bad_q <= bad;
		end
	end

	assign is_nul = (char_s1 == CH_NUL);
	assign is_ws  = char_s1 inside {[CH_TAB:CH_CR], CH_SPACE};

	// Only a NUL needs room in the result register.
	assign s1_adv      = !is_nul || !out_valid_q || result.ready;
	assign s1_fire     = valid_s1 && s1_adv;
	assign chars.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.character;
		end
	end

	assign mac = (acc_q * {27'd0, radix_q}) + {{(32-IDX_W){1'b0}}, digit.index};

	// One byte moves the parse on by at most one phase change and one digit.
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		ph_eff  = phase_q;
		if (is_nul) begin
			phase_d = PH_SPACE;
			neg_d   = 1'b0;
			acc_d   = '0;
		end else begin
			if (phase_q == PH_SPACE && !is_ws) begin
				ph_eff = PH_SIGN;
			end
			case (ph_eff)
				PH_SIGN: begin
					if (char_s1 == CH_PLUS) begin
						phase_d = PH_SIGN;
					end else if (char_s1 == CH_MINUS) begin
						phase_d = PH_SIGN;
						neg_d   = ~neg_q;
					end else if (digit.hit) begin
						phase_d = PH_DIGIT;
						acc_d   = mac;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				PH_DIGIT: begin
					if (digit.hit) begin
						acc_d = mac;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (s1_fire) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
		end
	end

	assign signed_acc = neg_q ? (32'd0 - acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && is_nul) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && is_nul) begin
			out_value_q   <= bad_q ? '0 : $signed(signed_acc);
			out_invalid_q <= bad_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.value            = out_value_q;
	assign result.alphabet_invalid = out_invalid_q;

	// An invalid alphabet always reports zero.
	`RSTI_ASSERT_IMPLY(a_invalid_zero, out_valid_q && out_invalid_q, out_value_q == 32'sd0)
	// A NUL leaves an empty parse behind.
	`RSTI_ASSERT_NEXT(a_nul_clears, s1_fire && is_nul,
		phase_q == PH_SPACE && !neg_q && acc_q == 32'd0)
	// Once digits have ended, only a NUL leaves the ignore phase.
	`RSTI_ASSERT_NEXT(a_ignore_sticks, phase_q == PH_IGNORE && !(s1_fire && is_nul),
		phase_q == PH_IGNORE)
	// The accumulator moves only when a byte is consumed.
	`RSTI_ASSERT_NEXT(a_acc_hold, !s1_fire, $stable(acc_q))

endmodule

// File: dv/tb.sv
// Self-checking testbench for the radix string-to-integer converter.
`default_nettype none

module tb;
	import rsti_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Index 3 maps to no register, so a write to it must change nothing.
	localparam cfg_index_t CFG_UNMAPPED = 2'd3;

	// Where the parse stands inside one number.
	typedef enum logic [1:0] {
		SKIP_SPACE,
		READ_SIGNS,
		READ_DIGITS,
		DISCARD
	} parse_phase_e;

	// One word as the result channel should carry it.
	typedef struct {
		logic signed [31:0] value;
		logic               invalid;
	} parse_word_t;

	logic clk;
	logic arst_n;

	rsti_cfg_if    cfg_ch();
	rsti_chars_if  chars_ch();
	rsti_result_if result_ch();

	radix_string_to_integer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.chars  (chars_ch),
		.result (result_ch)
	);

	// The alphabet as the block should currently hold it, updated whenever a
	// configuration word is accepted.
	symbols_t alpha_lo = SYMBOLS_LOW_RST;
	symbols_t alpha_hi = SYMBOLS_HIGH_RST;
	radix_t   alpha_radix = RADIX_RST;

	// Parse state of the number currently being read.
	parse_phase_e phase_q = SKIP_SPACE;
	logic         minus_q = 1'b0;
	logic [31:0]  acc_q = '0;

	// Result words that the block still owes us, oldest first.
	parse_word_t awaited_words[$];

	// Idle rates, in percent, of the byte sender and the result receiver.
	int send_idle_pct = 20;
	int recv_idle_pct = 20;

	int failures = 0;
	int chars_sent = 0;
	int words_checked = 0;
	int invalid_words = 0;
	int negative_words = 0;
	int alphabets_programmed = 0;

	// A free-running 2 ns clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs; no correct run gets near it.
	initial begin
		#1_000_000;
		$display("Timeout: the run did not finish, %0d result words outstanding",
			awaited_words.size());
		$display("tb failed");
		$finish;
	end

	// The receiver starts out not ready, then drops ready at random at every
	// falling edge, at the rate of the current phase.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Symbol k of the alphabet: the low register holds symbols 0 to 7 and the
	// high register symbols 8 to 15, one per byte, lowest byte first.
	function automatic byte_t alpha_symbol(int k);
		return (k < 8) ? alpha_lo[8*k +: 8] : alpha_hi[8*(k-8) +: 8];
	endfunction

	// An alphabet is unusable when the radix is out of range, when one of the
	// symbols in use is NUL, a sign or a space, or when a symbol repeats.
	function automatic logic alphabet_broken();
		int i, j;
		byte_t s;
		if (alpha_radix < 2 || alpha_radix > MAX_RADIX)
			return 1'b1;
		for (i = 0; i < alpha_radix; i++) begin
			s = alpha_symbol(i);
			if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || s == CH_SPACE)
				return 1'b1;
			for (j = i + 1; j < alpha_radix; j++)
				if (alpha_symbol(j) == s)
					return 1'b1;
		end
		return 1'b0;
	endfunction

	// Lowest alphabet position that holds c among the symbols in use, or -1
	// when c is no digit. A radix above the maximum still looks at 16 symbols.
	function automatic int digit_value(byte_t c);
		int i, used;
		used = (alpha_radix > MAX_RADIX) ? MAX_RADIX : alpha_radix;
		for (i = 0; i < used; i++)
			if (alpha_symbol(i) == c)
				return i;
		return -1;
	endfunction

	// Advance the predicted parse by one accepted byte. A NUL closes the number
	// and queues the word it must produce; every other byte produces nothing.
	function automatic void absorb_char(byte_t c);
		parse_word_t w;
		int d;
		if (c == CH_NUL) begin
			w.invalid = alphabet_broken();
			w.value = w.invalid ? 32'sd0 : (minus_q ? -acc_q : acc_q);
			awaited_words.push_back(w);
			phase_q = SKIP_SPACE;
			minus_q = 1'b0;
			acc_q = '0;
			return;
		end
		if (phase_q == SKIP_SPACE) begin
			if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
				return;
			phase_q = READ_SIGNS;
		end
		if (phase_q == READ_SIGNS) begin
			if (c == CH_PLUS)
				return;
			if (c == CH_MINUS) begin
				minus_q = ~minus_q;
				return;
			end
			phase_q = READ_DIGITS;
		end
		if (phase_q == READ_DIGITS) begin
			d = digit_value(c);
			// The multiply uses the full register value and wraps at 32 bits.
			if (d >= 0)
				acc_q = acc_q * 32'(alpha_radix) + 32'(d);
			else
				phase_q = DISCARD;
		end
	endfunction

	function automatic void note_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Everything is observed at the rising edge, where the handshakes happen.
	// The result is checked before a new byte is absorbed so that a word is
	// never matched against an expectation queued at the same edge.
	always @(posedge clk) begin
		parse_word_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (awaited_words.size() == 0) begin
					note_failure($sformatf("result word with none pending: value %0d invalid %0b",
						result_ch.value, result_ch.alphabet_invalid));
				end else begin
					want = awaited_words.pop_front();
					if (result_ch.value !== want.value ||
					    result_ch.alphabet_invalid !== want.invalid)
						note_failure($sformatf(
							"value %0d invalid %0b, expected value %0d invalid %0b",
							result_ch.value, result_ch.alphabet_invalid,
							want.value, want.invalid));
					words_checked++;
					if (want.invalid)
						invalid_words++;
					if (want.value < 0)
						negative_words++;
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_SYMBOLS_LOW: begin
						alpha_lo = cfg_ch.data;
					end
					CFG_SYMBOLS_HIGH: begin
						alpha_hi = cfg_ch.data;
					end
					CFG_RADIX: begin
						alpha_radix = cfg_ch.data[4:0];
					end
					default: begin
					end
				endcase
			end
			if (chars_ch.valid && chars_ch.ready) begin
				absorb_char(chars_ch.character);
				chars_sent++;
			end
		end
	end

	// Offer one byte, after a random gap, and hold it until it is taken.
	// Called and returning at a falling edge; valid stays high on return so
	// that back-to-back bytes never drop it for a moment.
	task automatic send_char(byte_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_ch.valid <= 1'b0;
			@(negedge clk);
		end
		chars_ch.valid <= 1'b1;
		chars_ch.character <= c;
		do @(posedge clk); while (!chars_ch.ready);
		@(negedge clk);
	endtask

	// Send a text followed by the NUL that ends it.
	task automatic send_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(CH_NUL);
	endtask

	// Stop sending and wait until every owed word has come. After that, bytes
	// that produce no word are given time to leave the pipeline as well.
	task automatic wait_for_results();
		chars_ch.valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, symbols_t d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Load a whole alphabet while the block is idle. The radix word carries
	// random upper bits, which the block must drop, and now and then a write
	// to the unmapped index is slipped in between.
	task automatic program_alphabet(symbols_t lo, symbols_t hi, radix_t r);
		symbols_t radix_word;
		wait_for_results();
		radix_word = {$urandom, $urandom};
		radix_word[4:0] = r;
		write_reg(CFG_SYMBOLS_LOW, lo);
		if ($urandom_range(3) == 0)
			write_reg(CFG_UNMAPPED, {$urandom, $urandom});
		write_reg(CFG_SYMBOLS_HIGH, hi);
		write_reg(CFG_RADIX, radix_word);
		cfg_ch.valid <= 1'b0;
		alphabets_programmed++;
	endtask

	// Draw an alphabet of distinct legal symbols with a random radix. Unused
	// positions get arbitrary bytes, repeats and forbidden ones included, since
	// they must not count as digits. When asked, the alphabet is then broken
	// in one of the ways the check must catch.
	function automatic void random_alphabet(output symbols_t lo, output symbols_t hi,
			output radix_t r, input bit broken);
		logic [127:0] tbl;
		bit [255:0] taken;
		byte_t s;
		int n, k, a, b;
		n = $urandom_range(2, MAX_RADIX);
		tbl = {$urandom, $urandom, $urandom, $urandom};
		taken = '0;
		for (k = 0; k < n; k++) begin
			do s = byte_t'($urandom_range(255));
			while (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || s == CH_SPACE || taken[s]);
			taken[s] = 1'b1;
			tbl[8*k +: 8] = s;
		end
		if (broken) begin
			case ($urandom_range(3))
				0: begin
					n = $urandom_range(1);
				end
				1: begin
					n = $urandom_range(MAX_RADIX + 1, 31);
				end
				2: begin
					case ($urandom_range(3))
						0: s = CH_NUL;
						1: s = CH_PLUS;
						2: s = CH_MINUS;
						default: s = CH_SPACE;
					endcase
					a = $urandom_range(n - 1);
					tbl[8*a +: 8] = s;
				end
				default: begin
					a = $urandom_range(n - 2);
					b = $urandom_range(a + 1, n - 1);
					tbl[8*b +: 8] = tbl[8*a +: 8];
				end
			endcase
		end
		lo = tbl[63:0];
		hi = tbl[127:64];
		r = radix_t'(n);
	endfunction

	// The alphabet left by reset: whitespace and sign handling, a sign that
	// toggles back, the most negative value, an empty number, and a stray
	// byte that ends the digits with an all-ones byte ignored after it.
	task automatic test_reset_alphabet();
		send_text("\t\015 -+-ff");
		send_text("-80000000");
		send_text("");
		send_text("7g5\377");
	endtask

	// Every way an alphabet can fail its check, plus two legal corner cases:
	// a symbol repeated only beyond the radix, and a write to no register.
	task automatic test_invalid_alphabets();
		symbols_t lo, hi;
		byte_t bad_sym[4];
		int i;
		bad_sym = '{CH_NUL, CH_PLUS, CH_MINUS, CH_SPACE};
		for (i = 0; i < 4; i++) begin
			program_alphabet(SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST, radix_t'(i < 2 ? i : 15 + 2*i));
			send_text("-12");
		end
		program_alphabet('0, '0, RADIX_RST);
		send_text("12");
		program_alphabet('1, '1, RADIX_RST);
		send_text("12");
		foreach (bad_sym[i]) begin
			lo = SYMBOLS_LOW_RST;
			lo[8*(i+3) +: 8] = bad_sym[i];
			program_alphabet(lo, SYMBOLS_HIGH_RST, RADIX_RST);
			send_text("12");
		end
		// Symbol 8 repeats symbol 0: fatal with all 16 in use, harmless with 8.
		hi = SYMBOLS_HIGH_RST;
		hi[7:0] = "0";
		program_alphabet(SYMBOLS_LOW_RST, hi, RADIX_RST);
		send_text("12");
		program_alphabet(SYMBOLS_LOW_RST, hi, radix_t'(8));
		send_text("-778");
		program_alphabet(SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST, RADIX_RST);
		write_reg(CFG_UNMAPPED, '0);
		cfg_ch.valid <= 1'b0;
		send_text("-a");
	endtask

	// The smallest radix, including a full 32-bit word of ones, and decimal
	// up to the largest positive value and past the 32-bit wrap.
	task automatic test_radix_extremes();
		program_alphabet("fedcba10", "nmlkjihg", radix_t'(2));
		send_text("-101");
		repeat (32) send_char("1");
		send_char(CH_NUL);
		program_alphabet("76543210", "zzzzzz98", radix_t'(10));
		send_text("+2147483647");
		send_text("4294967297");
	endtask

	// Mostly well-formed numbers with random content over a changing alphabet,
	// mixed with broken tails and raw noise. Each alphabet change first drains
	// the block, which also exercises a sender that stops until all is done.
	task automatic test_random_traffic(int goal, int sender_gap_pct, int receiver_stall_pct);
		symbols_t lo, hi;
		radix_t r;
		int first, numbers, n, k, pick, used;
		send_idle_pct = sender_gap_pct;
		recv_idle_pct = receiver_stall_pct;
		first = chars_sent;
		numbers = 0;
		while (chars_sent - first < goal) begin
			if (numbers % 12 == 0) begin
				random_alphabet(lo, hi, r, $urandom_range(7) == 0);
				program_alphabet(lo, hi, r);
			end
			numbers++;
			if ($urandom_range(9) == 0) begin
				// Noise: arbitrary bytes, NUL among them.
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					send_char(byte_t'($urandom_range(255)));
				send_char(CH_NUL);
			end else begin
				n = $urandom_range(3);
				for (k = 0; k < n; k++) begin
					pick = $urandom_range(5);
					send_char(pick == 5 ? CH_SPACE : byte_t'(CH_TAB + pick));
				end
				n = $urandom_range(2);
				for (k = 0; k < n; k++)
					send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
				// Long runs of digits make the accumulator wrap.
				n = ($urandom_range(7) == 0) ? $urandom_range(13, 34) : $urandom_range(9);
				used = (alpha_radix > MAX_RADIX) ? MAX_RADIX : alpha_radix;
				for (k = 0; k < n && used > 0; k++)
					send_char(alpha_symbol($urandom_range(used - 1)));
				if ($urandom_range(4) == 0) begin
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++)
						send_char(byte_t'($urandom_range(1, 255)));
				end
				send_char(CH_NUL);
			end
		end
		wait_for_results();
	endtask

	initial begin
		// Every input is known from time zero, while reset is held.
		arst_n = 1'b0;
		chars_ch.valid <= 1'b0;
		chars_ch.character <= CH_NUL;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_SYMBOLS_LOW;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_alphabet();
		test_invalid_alphabets();
		test_radix_extremes();
		// Sender gaps against a slow receiver, then the reverse, then full rate.
		test_random_traffic(570, 35, 76);
		test_random_traffic(570, 76, 35);
		test_random_traffic(570, 0, 0);

		// Everything has drained; give a stray word time to show up.
		repeat (8) @(negedge clk);
		if (awaited_words.size() != 0)
			note_failure($sformatf("%0d result words never arrived", awaited_words.size()));

		$display("Sent %0d bytes through %0d alphabet settings; checked %0d result words.",
			chars_sent, alphabets_programmed, words_checked);
		$display("Of those, %0d came from invalid alphabets and %0d were negative; %0d failures.",
			invalid_words, negative_words, failures);
		if (failures == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
